[src/ttrc_pkg.sv]
package ttrc_pkg;

    // Recurrence constants
    localparam logic [7:0]  ALPHA_STEP   = 8'd17;
    localparam logic [7:0]  BETA_STEP    = 8'd31;
    localparam logic [15:0] FIRST_OFFSET = 16'd7;
    localparam logic [15:0] MODULUS      = 16'hFFFF;

    // Work queue depth
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified byte on its way from the front to the back end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] alpha;
        logic [7:0] beta;
    } item_t;

endpackage

[src/ttrc_in_if.sv]
interface ttrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);
endinterface

[src/ttrc_out_if.sv]
interface ttrc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    logic        final_res;

    modport source (output valid, output checksum, output final_res, input ready);
    modport sink   (input valid, input checksum, input final_res, output ready);
endinterface

[src/ttrc_front.sv]
module ttrc_front (
    input  logic            clk,
    input  logic            rst_n,
    ttrc_in_if.sink         msg,
    output logic            push_valid,
    input  logic            push_ready,
    output ttrc_pkg::item_t push_item
);

    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic       accept;

    assign accept     = msg.valid && push_ready;
    assign msg.ready  = push_ready;
    assign push_valid = msg.valid;

    // Position factors, both taken mod 256
    always_comb
    begin
        push_item.data_byte  = msg.data_byte;
        push_item.first_byte = msg.first_byte;
        push_item.last_byte  = msg.last_byte;
        push_item.alpha      = 8'(pos_reg * ttrc_pkg::ALPHA_STEP);
        push_item.beta       = 8'(pos_reg * ttrc_pkg::BETA_STEP);
    end

    // A first byte restarts the count: the next byte sits at position 1
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (msg.first_byte)
                pos_next = 8'd1;
            else
                pos_next = pos_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 8'd0;
        else
            pos_reg <= pos_next;
    end

endmodule

[src/ttrc_queue.sv]
module ttrc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  ttrc_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ttrc_pkg::item_t pop_item
);

    localparam int unsigned PTR_W = $clog2(ttrc_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(ttrc_pkg::QUEUE_DEPTH + 1);

    ttrc_pkg::item_t  entry_reg [ttrc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(ttrc_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ttrc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ttrc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[src/ttrc_back.sv]
module ttrc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  ttrc_pkg::item_t pop_item,
    ttrc_out_if.source      sum
);

    logic [15:0] older_reg;
    logic [15:0] newer_reg;
    logic        out_valid_reg;
    logic [15:0] checksum_reg;
    logic        final_reg;

    logic [8:0]  factor;
    logic [24:0] plus;
    logic [23:0] minus;
    logic [25:0] diff;
    logic        neg;
    logic [24:0] mag;
    logic [16:0] fold;
    logic [15:0] rem;
    logic [15:0] step_term;
    logic [15:0] term_next;
    logic        load;

    assign pop_ready     = !out_valid_reg || sum.ready;
    assign load          = pop_valid && pop_ready;
    assign sum.valid     = out_valid_reg;
    assign sum.checksum  = checksum_reg;
    assign sum.final_res = final_reg;

    // D = (byte + alpha) * newer - beta * older, reduced mod 65535.
    // For D < 0 the result is (D + 1) mod 65535; ~D equals -(D + 1).
    always_comb
    begin
        factor = 9'(pop_item.data_byte) + 9'(pop_item.alpha);
        plus   = 25'(factor) * 25'(newer_reg);
        minus  = 24'(pop_item.beta) * 24'(older_reg);
        diff   = {1'b0, plus} - {2'b0, minus};
        neg    = diff[25];
        mag    = neg ? ~diff[24:0] : diff[24:0];
        // 2^16 = 1 mod 65535: fold the high part onto the low part
        fold   = 17'(mag[24:16]) + 17'(mag[15:0]);
        rem    = (fold >= 17'(ttrc_pkg::MODULUS)) ?
                 16'(fold - 17'(ttrc_pkg::MODULUS)) : fold[15:0];
        if (!neg)
            step_term = rem;
        else if (rem == 16'd0)
            step_term = 16'd0;
        else
            step_term = ttrc_pkg::MODULUS - rem;

        if (pop_item.first_byte)
            term_next = 16'(pop_item.data_byte) + ttrc_pkg::FIRST_OFFSET;
        else
            term_next = step_term;
    end

    // Recurrence terms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= 16'd1;
            newer_reg <= 16'd1;
        end
        else if (load)
        begin
            older_reg <= pop_item.first_byte ? 16'd1 : newer_reg;
            newer_reg <= term_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (sum.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            checksum_reg <= term_next;
            final_reg    <= pop_item.last_byte;
        end
    end

endmodule

[src/three_term_recurrence_checksum_core.sv]
// Channel | Dir | Beat fields
// msg     | in  | data_byte[7:0], first_byte, last_byte
// sum     | out | checksum[15:0], final_res
//
// One beat per cycle sustained while sum.ready stays high; each byte yields one result beat.
// Between msg acceptance and sum valid a byte passes the queue entry, then the result register.
// The back end computes each term update in combinational logic (two narrow multiplies and a fold).
// rst_n is asynchronous: terms reset to 1, position to 0, queue and output empty.
// A stalled sum side fills the two-entry queue before msg.ready drops.
module three_term_recurrence_checksum_core (
    input  logic  clk,
    input  logic  rst_n,
    ttrc_in_if.sink    msg,
    ttrc_out_if.source sum
);

    logic            push_valid;
    logic            push_ready;
    ttrc_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    ttrc_pkg::item_t pop_item;

    ttrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ttrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ttrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .sum       (sum)
    );

`ifndef NO_ASSERTIONS
    // Queue is never empty and full at once
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        push_ready || pop_valid)
        else $error("queue reports empty and full together");

    // A first byte restarts the recurrence at byte plus offset
    a_first_term: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready && pop_item.first_byte) |=>
        (sum.valid && sum.checksum ==
            16'($past(pop_item.data_byte)) + ttrc_pkg::FIRST_OFFSET))
        else $error("first byte checksum mismatch");

    // Checksum is always reduced below the modulus
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        sum.valid |-> (sum.checksum != ttrc_pkg::MODULUS))
        else $error("checksum not reduced");
`endif

endmodule
